/* sv/power_iteration_eigenvalue_assert.svh */
// assertion macros for the power iteration rtl
// expects clk and rst_n in the including module
`ifndef POWER_ITERATION_EIGENVALUE_ASSERT_SVH
`define POWER_ITERATION_EIGENVALUE_ASSERT_SVH

// same-cycle implication
`define PIE_ASSERT_IMM(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pie_pkg.sv */
// shared types and constants of the power iteration eigenvalue block
// no dependencies
`default_nettype none

package pie_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] CFG_DIMENSION = 2'd0;
    localparam logic [1:0] CFG_MAX_ITER  = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [3:0]  DIMENSION_RST = 4'd8;
    localparam logic [15:0] MAX_ITER_RST  = 16'd1000;
    localparam logic [30:0] THRESHOLD_RST = 31'd1;

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_ZERO_DIV = 2'd1;
    localparam logic [1:0] FAULT_SAT      = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_READ,
        OP_MUL,
        OP_ACC_FIRST,
        OP_ACC,
        OP_ROW,
        OP_YREAD,
        OP_DIV_Y,
        OP_XWR,
        OP_DIV_ERR,
        OP_ERR_CHK
    } pie_op_t;

    typedef struct packed {
        pie_op_t op;
        logic    ld_we;
    } pie_cmd_t;

    typedef struct packed {
        logic lam_zero;
        logic conv;
        logic div_done;
    } pie_status_t;

endpackage

`default_nettype wire

/* sv/pie_div.sv */
// unsigned restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module pie_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [NW-1:0] quo,
    output logic               done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        if (!diff[DW])
        begin
            rem_next = diff[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* sv/pie_dp.sv */
// datapath: matrix and vector memories, multiply-accumulate, divider, flags
// depends on pie_pkg and pie_div
`default_nettype none

module pie_dp #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16,
    parameter int AW        = 6,
    parameter int IW        = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pie_pkg::pie_cmd_t  cmd,
    input  wire logic [AW-1:0]      a_addr,
    input  wire logic [IW-1:0]      v_idx,
    input  wire logic [31:0]        entry_value,
    input  wire logic [30:0]        threshold,
    output pie_pkg::pie_status_t    status,
    output logic [31:0]             res_eigenvalue,
    output logic                    res_converged,
    output logic [1:0]              res_fault
);
    import pie_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

    logic [31:0] amem [DEPTH];
    logic [31:0] xmem [MAX_DIM];
    logic [31:0] ymem [MAX_DIM];

    logic signed [31:0] a_q, x_q, y_q;
    logic signed [31:0] lam_reg, est_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic               first_reg, sat_reg, conv_reg, neg_reg;

    logic signed [31:0] xop;
    logic signed [63:0] sum;
    logic               add_ovf;
    logic signed [63:0] shifted;
    logic               row_fits;
    logic [31:0]        y_row;
    logic [31:0]        y_mag, lam_mag;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic               div_start;
    logic [NW-1:0]      div_num, quo;
    logic               div_done;
    logic               x_sat;
    logic [31:0]        x_new;

    assign xop = first_reg ? ONE_FX : x_q;

    always_comb
    begin
        sum     = acc_reg + prod_reg;
        add_ovf = (acc_reg[63] == prod_reg[63]) && (sum[63] != acc_reg[63]);
        shifted = acc_reg >>> FRAC_BITS;
        row_fits = (&shifted[63:31]) || !(|shifted[63:31]);
        if (row_fits)
            y_row = shifted[31:0];
        else
            y_row = shifted[63] ? 32'h8000_0000 : 32'h7fff_ffff;
    end

    always_comb
    begin
        y_mag    = y_q[31] ? 32'(-y_q) : y_q;
        lam_mag  = lam_reg[31] ? 32'(-lam_reg) : lam_reg;
        diff     = {lam_reg[31], lam_reg} - {est_reg[31], est_reg};
        diff_mag = diff[32] ? 33'(-diff) : diff;
        div_start = (cmd.op == OP_DIV_Y) || (cmd.op == OP_DIV_ERR);
        if (cmd.op == OP_DIV_Y)
            div_num = NW'({y_mag, FRAC_BITS'(0)});
        else
            div_num = {diff_mag, FRAC_BITS'(0)};
    end

    // signed saturation of the vector quotient
    always_comb
    begin
        x_sat = 1'b0;
        if (!neg_reg)
        begin
            if (quo > NW'(32'h7fff_ffff))
            begin
                x_sat = 1'b1;
                x_new = 32'h7fff_ffff;
            end
            else
                x_new = quo[31:0];
        end
        else
        begin
            if (quo > NW'(32'h8000_0000))
            begin
                x_sat = 1'b1;
                x_new = 32'h8000_0000;
            end
            else
                x_new = 32'(-quo[31:0]);
        end
    end

    pie_div #(.NW(NW), .DW(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (lam_mag),
        .quo   (quo),
        .done  (div_done)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.ld_we)
            amem[a_addr] <= entry_value;
        if (cmd.op == OP_READ)
            a_q <= amem[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_XWR)
            xmem[v_idx] <= x_new;
        if (cmd.op == OP_READ)
            x_q <= xmem[v_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ROW)
            ymem[v_idx] <= y_row;
        if (cmd.op == OP_YREAD)
            y_q <= ymem[v_idx];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MUL:       prod_reg <= 64'(a_q) * 64'(xop);
            OP_ACC_FIRST: acc_reg  <= prod_reg;
            OP_ACC:       acc_reg  <= add_ovf ? (acc_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                                              : sum;
            OP_DIV_Y:     neg_reg  <= y_q[31] ^ lam_reg[31];
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lam_reg   <= ONE_FX;
            est_reg   <= ONE_FX;
            first_reg <= 1'b1;
            sat_reg   <= 1'b0;
            conv_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_INIT:
                begin
                    est_reg   <= ONE_FX;
                    first_reg <= 1'b1;
                    sat_reg   <= 1'b0;
                    conv_reg  <= 1'b0;
                end
                OP_ACC:
                    if (add_ovf)
                        sat_reg <= 1'b1;
                OP_ROW:
                begin
                    if (!row_fits)
                        sat_reg <= 1'b1;
                    if (v_idx == '0)
                        lam_reg <= y_row;
                end
                OP_XWR:
                    if (x_sat)
                        sat_reg <= 1'b1;
                OP_DIV_ERR:
                    first_reg <= 1'b0;
                OP_ERR_CHK:
                begin
                    conv_reg <= (quo <= NW'(threshold));
                    est_reg  <= lam_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.lam_zero = (lam_reg == '0);
        status.conv     = conv_reg;
        status.div_done = div_done;
        res_eigenvalue  = status.lam_zero ? 32'd0 : est_reg;
        res_converged   = !status.lam_zero && conv_reg;
        if (status.lam_zero)
            res_fault = FAULT_ZERO_DIV;
        else if (sat_reg)
            res_fault = FAULT_SAT;
        else
            res_fault = FAULT_NONE;
    end

endmodule

`default_nettype wire

/* sv/pie_ctrl.sv */
// controller: load counter, pass/row/column sequencing, result hand-off
// depends on pie_pkg and power_iteration_eigenvalue_assert.svh
`default_nettype none
`include "power_iteration_eigenvalue_assert.svh"

module pie_ctrl #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6,
    parameter int IW      = 3,
    parameter int DIM_W   = 4,
    parameter int CNT_W   = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [DIM_W-1:0]     n_use,
    input  wire logic [15:0]          limit,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 out_busy,
    output logic                      out_load,
    output logic [15:0]               pass_count,
    input  wire pie_pkg::pie_status_t status,
    output pie_pkg::pie_cmd_t         cmd,
    output logic [AW-1:0]             a_addr,
    output logic [IW-1:0]             v_idx
);
    import pie_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_RD, S_MUL, S_ACC, S_ROW, S_PASS, S_YRD, S_DIVY,
        S_WAITY, S_XWR, S_DIVE, S_WAITE, S_ECHK, S_TEST, S_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IW-1:0]    i_reg, j_reg;
    logic [AW-1:0]    row_base_reg;
    logic [15:0]      pass_reg;

    logic [IW-1:0]    n_last;
    logic [CNT_W-1:0] nn;
    logic [CNT_W-1:0] cnt_inc;
    logic             accept;

    assign n_last  = IW'(n_use - 1'b1);
    assign nn      = CNT_W'(n_use) * CNT_W'(n_use);
    assign cnt_inc = cnt_reg + 1'b1;
    assign in_ready = (state_reg == S_LOAD);
    assign accept  = in_valid && in_ready;
    assign out_load = (state_reg == S_EMIT) && !out_busy;
    assign pass_count = pass_reg;

    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.ld_we = 1'b0;
        a_addr    = row_base_reg + AW'(j_reg);
        v_idx     = i_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                a_addr    = cnt_reg[AW-1:0];
                cmd.ld_we = accept;
                if (accept && cnt_inc >= nn)
                    cmd.op = OP_INIT;
            end
            S_RD:
            begin
                cmd.op = OP_READ;
                v_idx  = j_reg;
            end
            S_MUL:   cmd.op = OP_MUL;
            S_ACC:   cmd.op = (j_reg == '0) ? OP_ACC_FIRST : OP_ACC;
            S_ROW:   cmd.op = OP_ROW;
            S_YRD:   cmd.op = OP_YREAD;
            S_DIVY:  cmd.op = OP_DIV_Y;
            S_XWR:   cmd.op = OP_XWR;
            S_DIVE:  cmd.op = OP_DIV_ERR;
            S_ECHK:  cmd.op = OP_ERR_CHK;
            S_PASS, S_WAITY, S_WAITE, S_TEST, S_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            row_base_reg <= '0;
            pass_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                    if (accept)
                    begin
                        if (cnt_inc >= nn)
                        begin
                            cnt_reg      <= '0;
                            pass_reg     <= '0;
                            i_reg        <= '0;
                            j_reg        <= '0;
                            row_base_reg <= '0;
                            state_reg    <= S_RD;
                        end
                        else
                            cnt_reg <= cnt_inc;
                    end
                S_RD:  state_reg <= S_MUL;
                S_MUL: state_reg <= S_ACC;
                S_ACC:
                    if (j_reg == n_last)
                        state_reg <= S_ROW;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                S_ROW:
                begin
                    j_reg <= '0;
                    if (i_reg == n_last)
                    begin
                        i_reg     <= '0;
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= S_PASS;
                    end
                    else
                    begin
                        i_reg        <= i_reg + 1'b1;
                        row_base_reg <= row_base_reg + AW'(n_use);
                        state_reg    <= S_RD;
                    end
                end
                S_PASS: state_reg <= status.lam_zero ? S_EMIT : S_YRD;
                S_YRD:  state_reg <= S_DIVY;
                S_DIVY: state_reg <= S_WAITY;
                S_WAITY:
                    if (status.div_done)
                        state_reg <= S_XWR;
                S_XWR:
                    if (i_reg == n_last)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_DIVE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_YRD;
                    end
                S_DIVE: state_reg <= S_WAITE;
                S_WAITE:
                    if (status.div_done)
                        state_reg <= S_ECHK;
                S_ECHK: state_reg <= S_TEST;
                S_TEST:
                    if (status.conv || pass_reg >= limit)
                        state_reg <= S_EMIT;
                    else
                    begin
                        row_base_reg <= '0;
                        state_reg    <= S_RD;
                    end
                S_EMIT:
                    if (!out_busy)
                        state_reg <= S_LOAD;
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    `PIE_ASSERT_NXT(a_emit_returns, out_load, in_ready, "result hand-off did not return to loading")
    `PIE_ASSERT_IMM(a_pass_bound, state_reg == S_TEST, pass_reg != 16'd0 && pass_reg <= limit, "pass count out of range")
    `PIE_ASSERT_IMM(a_index_bound, state_reg != S_LOAD, i_reg <= n_last && j_reg <= n_last, "row or column index past matrix order")

endmodule

`default_nettype wire

/* sv/power_iteration_eigenvalue.sv */
// power iteration dominant eigenvalue unit, top level
// depends on pie_pkg, pie_ctrl, pie_dp (and pie_div below it)
//
// usage: matrix entries (signed q.frac) arrive on s_axis in row-major order,
// one transaction per cycle while loading. when n*n entries have arrived the
// block stops taking input and runs power iteration from the all-ones vector.
// each pass walks the matrix memory one entry at a time through the read,
// multiply and accumulate states, and the shared bit-serial divider then
// produces each quotient of the pass, one for every row and the error.
// the run ends after max_iterations passes, on convergence or on a zero
// divisor, and one result transaction is offered on m_axis from an output
// register. loading of the next matrix starts as soon as the result sits in
// that register; if the receiver stalls a second result waits in the
// controller until the register drains. the cfg channel is always ready and
// should only be written while idle. reset clears control state and restores
// dimension 8, max_iterations 1000, threshold 1; no memory clearing is done.
`default_nettype none

module power_iteration_eigenvalue #(
    parameter int MAX_DIM   = pie_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = pie_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] entry_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [31:0] eigenvalue, [47:32] passes_used,
                                             // [48] converged, [50:49] fault, rest zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pie_pkg::*;

    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);

    logic [3:0]  dimension_reg;
    logic [15:0] max_iter_reg;
    logic [30:0] threshold_reg;

    logic [DIM_W-1:0] n_use;
    logic [15:0]      limit;

    logic             out_valid_reg;
    logic [31:0]      eig_reg;
    logic [15:0]      passes_reg;
    logic             conv_reg;
    logic [1:0]       fault_reg;

    logic             out_busy, out_load;
    logic [15:0]      pass_count;
    pie_status_t      status;
    pie_cmd_t         cmd;
    logic [AW-1:0]    a_addr;
    logic [IW-1:0]    v_idx;
    logic [31:0]      res_eigenvalue;
    logic             res_converged;
    logic [1:0]       res_fault;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIMENSION_RST;
            max_iter_reg  <= MAX_ITER_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIMENSION: dimension_reg <= cfg_data[3:0];
                CFG_MAX_ITER:  max_iter_reg  <= cfg_data[15:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (dimension_reg == '0)
            n_use = DIM_W'(1);
        else if (32'(dimension_reg) > MAX_DIM)
            n_use = DIM_W'(MAX_DIM);
        else
            n_use = DIM_W'(dimension_reg);
        limit = (max_iter_reg == '0) ? 16'd1 : max_iter_reg;
    end

    assign out_busy = out_valid_reg && !m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            eig_reg    <= res_eigenvalue;
            passes_reg <= pass_count;
            conv_reg   <= res_converged;
            fault_reg  <= res_fault;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, fault_reg, conv_reg, passes_reg, eig_reg};

    pie_ctrl #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW),
        .IW      (IW),
        .DIM_W   (DIM_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .n_use      (n_use),
        .limit      (limit),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .out_busy   (out_busy),
        .out_load   (out_load),
        .pass_count (pass_count),
        .status     (status),
        .cmd        (cmd),
        .a_addr     (a_addr),
        .v_idx      (v_idx)
    );

    pie_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .IW        (IW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .a_addr         (a_addr),
        .v_idx          (v_idx),
        .entry_value    (s_axis_tdata),
        .threshold      (threshold_reg),
        .status         (status),
        .res_eigenvalue (res_eigenvalue),
        .res_converged  (res_converged),
        .res_fault      (res_fault)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the power iteration eigenvalue block
// depends on pie_pkg and power_iteration_eigenvalue; a scoreboard class predicts each solve
`default_nettype none

module tb;
    import pie_pkg::*;

    localparam int N_ENTRIES = 1850;
    localparam int CALM_FROM = 1550;

    typedef struct {
        logic signed [31:0] eig;
        logic [15:0]        passes;
        logic               conv;
        logic [1:0]         fault;
    } eig_result_t;

    class eig_scoreboard;
        logic [3:0]         dim_reg;
        logic [15:0]        iter_reg;
        logic [30:0]        thr_reg;
        logic signed [31:0] mat[64];
        int                 fill;
        eig_result_t        expected_q[$];
        int                 errors;
        int                 solves;
        int                 n_conv;
        int                 n_zero;
        int                 n_sat;

        function new();
            dim_reg  = DIMENSION_RST;
            iter_reg = MAX_ITER_RST;
            thr_reg  = THRESHOLD_RST;
            fill     = 0;
            errors   = 0;
            solves   = 0;
            n_conv   = 0;
            n_zero   = 0;
            n_sat    = 0;
        endfunction

        function int order();
            if (dim_reg == 0)
                return 1;
            if (dim_reg > MAX_DIM_DEF)
                return MAX_DIM_DEF;
            return dim_reg;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                CFG_DIMENSION: dim_reg  = d[3:0];
                CFG_MAX_ITER:  iter_reg = d[15:0];
                CFG_THRESHOLD: thr_reg  = d[30:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clip32(longint v, inout bit sat);
            if (v > 64'sd2147483647)
            begin
                sat = 1;
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648)
            begin
                sat = 1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        function void solve_matrix();
            int                 n;
            int                 limit;
            int                 passes;
            bit                 sat;
            bit                 zero;
            bit                 conv;
            logic signed [31:0] x[8];
            logic signed [31:0] y[8];
            logic signed [31:0] lam;
            logic signed [31:0] est;
            longint             acc;
            longint             p;
            longint             s;
            longint             diff;
            longint unsigned    ad;
            longint unsigned    al;
            longint unsigned    err;
            eig_result_t        r;
            n      = order();
            limit  = (iter_reg == 0) ? 1 : iter_reg;
            passes = 0;
            sat    = 0;
            zero   = 0;
            conv   = 0;
            est    = 32'sh00010000;
            for (int i = 0; i < 8; i++)
                x[i] = 32'sh00010000;
            do
            begin
                for (int i = 0; i < n; i++)
                begin
                    acc = 0;
                    for (int j = 0; j < n; j++)
                    begin
                        p = longint'(mat[i * n + j]) * longint'(x[j]);
                        s = acc + p;
                        // 64-bit accumulate saturates instead of wrapping
                        if (p > 0 && s < acc)
                        begin
                            sat = 1;
                            s   = 64'sh7fffffffffffffff;
                        end
                        else if (p < 0 && s > acc)
                        begin
                            sat = 1;
                            s   = 64'sh8000000000000000;
                        end
                        acc = s;
                    end
                    y[i] = clip32(acc >>> FRAC_BITS_DEF, sat);
                end
                lam = y[0];
                passes++;
                if (lam == 0)
                begin
                    zero = 1;
                    conv = 0;
                    break;
                end
                for (int i = 0; i < n; i++)
                    x[i] = clip32((longint'(y[i]) * 65536) / longint'(lam), sat);
                diff = longint'(lam) - longint'(est);
                ad   = (diff < 0) ? -diff : diff;
                al   = (lam < 0) ? -longint'(lam) : longint'(lam);
                err  = (ad << FRAC_BITS_DEF) / al;
                est  = lam;
                conv = (err <= thr_reg);
            end
            while (passes < limit && !conv);
            r.eig    = zero ? 32'sd0 : est;
            r.passes = passes[15:0];
            r.conv   = conv;
            r.fault  = zero ? FAULT_ZERO_DIV : (sat ? FAULT_SAT : FAULT_NONE);
            expected_q.push_back(r);
        endfunction

        function void note_entry(logic [31:0] d);
            int n;
            n = order();
            if (fill < 64)
                mat[fill] = d;
            fill++;
            if (fill >= n * n)
            begin
                fill = 0;
                solve_matrix();
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [55:0] d);
            eig_result_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h with nothing expected", d));
                return;
            end
            e = expected_q.pop_front();
            solves++;
            if (e.conv)
                n_conv++;
            if (e.fault == FAULT_ZERO_DIV)
                n_zero++;
            if (e.fault == FAULT_SAT)
                n_sat++;
            if (d[31:0] !== e.eig)
                report($sformatf("eigenvalue %h, want %h", d[31:0], e.eig));
            if (d[47:32] !== e.passes)
                report($sformatf("passes_used %0d, want %0d", d[47:32], e.passes));
            if (d[48] !== e.conv)
                report($sformatf("converged %b, want %b", d[48], e.conv));
            if (d[50:49] !== e.fault)
                report($sformatf("fault %0d, want %0d", d[50:49], e.fault));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    eig_scoreboard sb = new();
    int            entries_sent = 0;
    bit            calm = 0;
    bit            hold_on = 0;

    power_iteration_eigenvalue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("FAILURE");
        $finish;
    end

    // transaction monitors feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_entry(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // result side backpressure, including one long hold-off
    initial
    begin
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_on)
            begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge clk);
                hold_on = 0;
            end
            else if (calm || $urandom_range(0, 1))
            begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 32)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task send_entry(logic [31:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        entries_sent++;
    endtask

    // mask bit i selects register i
    task write_regs(logic [2:0] mask, logic [31:0] dim_v, logic [31:0] iter_v,
                    logic [31:0] thr_v);
        for (int i = 0; i < 3; i++)
        begin
            if (mask[i])
            begin
                cfg_valid <= 1;
                cfg_index <= (i == 0) ? CFG_DIMENSION : (i == 1) ? CFG_MAX_ITER : CFG_THRESHOLD;
                cfg_data  <= (i == 0) ? dim_v : (i == 1) ? iter_v : thr_v;
                do @(posedge clk); while (!cfg_ready);
            end
        end
        cfg_valid <= 0;
        // let the monitor log the last write before the scoreboard is consulted
        @(posedge clk);
    endtask

    task settle();
        s_axis_tvalid <= 0;
        // the monitor may not have noted the last entry yet
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function logic [31:0] pick_entry(int kind, int i, int j);
        case (kind)
            0: return (i == j) ? ($urandom_range(2, 8) << 16) :
                                 ($urandom_range(0, 32'h10000) - 32'h8000);
            1: return $urandom_range(0, 32'h80000) - 32'h40000;
            2: return $urandom;
            default: return (i == 0) ? 32'd0 : ($urandom_range(0, 32'h20000) - 32'h10000);
        endcase
    endfunction

    task send_matrix(int n, int kind);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                send_entry(pick_entry(kind, i, j));
    endtask

    initial
    begin
        int r;
        int dim_v;
        int n;
        int iter_v;
        int thr_v;
        int phase;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        cfg_valid     = 0;
        cfg_index     = CFG_DIMENSION;
        cfg_data      = 0;
        rst_n         = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // dimension zero acts as one, zero iteration limit still runs a pass
        write_regs(3'b111, 32'd0, 32'd0, 32'd0);
        send_entry(32'h7fffffff);
        send_entry(32'h80000000);
        send_entry(32'h00000000);
        send_entry(32'h00010000);
        settle();
        // convergence on the last allowed pass
        write_regs(3'b011, 32'd1, 32'd2, 32'd0);
        send_entry(32'h00050000);
        send_entry(32'hffff0000);
        settle();
        write_regs(3'b010, 32'd0, 32'd65535, 32'd0);
        send_entry(32'h00030000);
        settle();
        // saturating sums, then a plain 2x2 with the widest threshold
        write_regs(3'b111, 32'd2, 32'd8, 32'h7fffffff);
        repeat (4) send_entry(32'h7fffffff);
        repeat (4) send_entry(32'h80000000);
        send_entry(32'h00020000);
        send_entry(32'h00010000);
        send_entry(32'h00010000);
        send_entry(32'h00020000);
        settle();
        // zero divisor after a real pass
        send_entry(32'h00000000);
        send_entry(32'h00000000);
        send_entry(32'h00010000);
        send_entry(32'h00010000);
        settle();

        phase = 0;
        while (entries_sent < N_ENTRIES)
        begin
            calm = (entries_sent >= CALM_FROM);
            settle();
            if (phase == 10)
            begin
                // hold the result side so the block fills and stalls its input
                write_regs(3'b111, 32'd1, 32'd4, 32'd0);
                hold_on = 1;
                repeat (20) send_entry(pick_entry(1, 0, 0));
                settle();
                // sender pauses here until the block drained
            end
            r = $urandom_range(0, 99);
            dim_v = (r < 12) ? 0 : (r < 25) ? 1 : (r < 55) ? 2 : (r < 75) ? 3 :
                    (r < 85) ? 4 : (r < 93) ? $urandom_range(5, 8) : $urandom_range(9, 15);
            n = (dim_v == 0) ? 1 : (dim_v > 8) ? 8 : dim_v;
            if (n >= 3)
                iter_v = $urandom_range(1, 12);
            else if (n == 1 && $urandom_range(0, 4) == 0)
                iter_v = $urandom_range(0, 1) ? 65535 : 0;
            else
                iter_v = $urandom_range(0, 40);
            r = $urandom_range(0, 3);
            thr_v = (r == 0) ? 0 : (r == 1) ? 32'h7fffffff :
                    (r == 2) ? $urandom_range(0, 32'h2000) : $urandom;
            write_regs((phase == 0) ? 3'b111 : (3'b001 | $urandom_range(0, 7)),
                       32'({$urandom_range(0, 32'h0fffffff), dim_v[3:0]}),
                       32'({$urandom_range(0, 16'hffff), iter_v[15:0]}),
                       32'({$urandom_range(0, 1), thr_v[30:0]}));
            // keep the solve bounded even when the iteration limit was not rewritten
            if (sb.iter_reg > 40 && !(sb.order() == 1))
                write_regs(3'b010, 0, $urandom_range(1, 12), 0);
            n = sb.order();
            repeat ($urandom_range(1, 6))
            begin
                r = $urandom_range(0, 99);
                send_matrix(n, (r < 60) ? 0 : (r < 80) ? 1 : (r < 92) ? 2 : 3);
            end
            phase++;
        end

        settle();
        repeat (200) @(posedge clk);
        $display("covered %0d solves: %0d converged, %0d zero divisor, %0d saturated",
                 sb.solves, sb.n_conv, sb.n_zero, sb.n_sat);
        $display("%0d matrix entries sent over %0d configuration phases",
                 entries_sent, phase);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
